@@ rtl/core/trzs_pkg.sv @@
`timescale 1ns / 1ps

package trzs_pkg;

    // Sizing of the history ring and the record index
    localparam int HISTORY_DEPTH = 16;
    localparam int INDEX_BITS    = 16;
    localparam int PRE_CAP       = 16;
    localparam int PRE_LIM       = (PRE_CAP < HISTORY_DEPTH) ? PRE_CAP : HISTORY_DEPTH;
    localparam int HIST_AW       = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int PRE_W         = $clog2(PRE_LIM + 1);

    // Field widths
    localparam int VALUE_W   = 16;
    localparam int OUT_IDX_W = 16;
    localparam int CHAN_W    = 10;
    localparam int PRE_CFG_W = 5;
    localparam int WIN_W     = 8;

    // Register reset values
    localparam logic [PRE_CFG_W-1:0] PRE_COUNT_RESET  = 5'd10;
    localparam logic [WIN_W-1:0]     WINDOW_LEN_RESET = 8'd40;

    // APB port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // History memory access
    typedef struct packed {
        logic               wr_en;
        logic [HIST_AW-1:0] wr_addr;
        logic [VALUE_W-1:0] wr_data;
        logic               rd_en;
        logic [HIST_AW-1:0] rd_addr;
    } hist_req_t;

    // One output word
    typedef struct packed {
        logic [VALUE_W-1:0]   value;
        logic [OUT_IDX_W-1:0] index;
        logic [CHAN_W-1:0]    channel;
        logic                 last;
    } out_word_t;

    // Low bits of a record index as carried on the output
    function automatic logic [OUT_IDX_W-1:0] to_out_index(input logic [INDEX_BITS-1:0] idx);
        logic [OUT_IDX_W+INDEX_BITS-1:0] ext;
        ext = {{OUT_IDX_W{1'b0}}, idx};
        return ext[OUT_IDX_W-1:0];
    endfunction

endpackage

@@ rtl/core/trzs_hist_ram.sv @@
`timescale 1ns / 1ps

module trzs_hist_ram
    import trzs_pkg::*;
(
    input  logic               clk,
    input  hist_req_t          req,
    output logic [VALUE_W-1:0] rd_data
);

    logic [VALUE_W-1:0] mem [HISTORY_DEPTH];
    logic [VALUE_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // registered read, held while no read is issued
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/trzs_out_reg.sv @@
`timescale 1ns / 1ps

module trzs_out_reg
    import trzs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  out_word_t word_in,
    output logic      free,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t word_out
);

    logic      valid_reg;
    out_word_t word_reg;

    // slot can take a new word when empty or being drained this cycle
    assign free = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word_in;
        end
    end

    assign out_valid = valid_reg;
    assign word_out  = word_reg;

endmodule

@@ rtl/core/threshold_roi_zero_suppress.sv @@
`timescale 1ns / 1ps

// Threshold zero suppression with regions of interest.
// Input channel (in_valid/in_ready): one ADC word per item with its channel's
// threshold, channel number and end-of-record flag. Output channel
// (out_valid/out_ready): the words of each region of interest with their index
// in the record, channel number and roi_last on the final word of the region.
// A crossing emits up to pre_count stored history words, oldest first, then
// the crossing word; the next window_len-1 words follow, and a record end
// closes an open region on its current word.
// The control sequencer handles one item at a time, and each history word
// costs one read of the history memory plus one output load.
// Output stalls hold the sequencer in its emit states; the output register
// lets the next item be accepted while the last word still waits.
// Reset clears the sequencer, the record state and the output register and
// restores pre_count to 10 and window_len to 40; the history memory needs no
// clearing, only words of the current record are read back.
// pre_count and window_len are written over APB at addresses 0 and 4.
module threshold_roi_zero_suppress
    import trzs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input words
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [VALUE_W-1:0]   sample_value,
    input  logic [VALUE_W-1:0]   threshold,
    input  logic [CHAN_W-1:0]    channel_id,
    input  logic                 record_last,
    // output words
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [VALUE_W-1:0]   out_value,
    output logic [OUT_IDX_W-1:0] out_index,
    output logic [CHAN_W-1:0]    out_channel,
    output logic                 roi_last,
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready
);

    typedef enum logic [0:0] {
        REG_PRE_COUNT,
        REG_WINDOW_LEN
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PLAN,
        S_RD,
        S_PRE,
        S_LAST
    } state_t;

    localparam logic [INDEX_BITS-1:0] IDX_MAX = {INDEX_BITS{1'b1}};
    localparam int SUM_W = HIST_AW + 2;

    // configuration registers
    logic [PRE_CFG_W-1:0] pre_count_reg;
    logic [WIN_W-1:0]     window_len_reg;
    reg_idx_t             cfg_idx;

    // sequencer and record state
    state_t               state_reg;
    logic [VALUE_W-1:0]   val_reg;
    logic [VALUE_W-1:0]   thr_reg;
    logic [CHAN_W-1:0]    chan_reg;
    logic                 rlast_reg;
    logic                 in_win_reg;
    logic [WIN_W-1:0]     win_left_reg;
    logic [INDEX_BITS-1:0] cnt_reg;
    logic [INDEX_BITS-1:0] cur_reg;
    logic [INDEX_BITS-1:0] last_em_reg;
    logic                 em_valid_reg;
    logic [HIST_AW-1:0]   pos_reg;
    logic [PRE_W-1:0]     k_reg;
    logic                 flag_reg;

    // plan of the current item
    logic                 hit;
    logic                 emit_plan;
    logic [PRE_W-1:0]     pre_cap;
    logic [PRE_W-1:0]     pre_cur;
    logic [PRE_W-1:0]     pre_plan;
    logic [INDEX_BITS-1:0] gap;
    logic [WIN_W-1:0]     wl_new;
    logic [HIST_AW:0]     pos_inc;
    logic [HIST_AW-1:0]   pos_next;
    logic [SUM_W-1:0]     slot_sum;

    // memory, output register
    hist_req_t            hist_req;
    logic [VALUE_W-1:0]   hist_rd_data;
    logic                 out_free;
    logic                 out_load;
    out_word_t            out_word_in;
    out_word_t            out_word;

    // APB register access
    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_count_reg  <= PRE_COUNT_RESET;
            window_len_reg <= WINDOW_LEN_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (cfg_idx)
                REG_PRE_COUNT:  pre_count_reg  <= pwdata[PRE_CFG_W-1:0];
                REG_WINDOW_LEN: window_len_reg <= pwdata[WIN_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_PRE_COUNT:  prdata = {{(APB_DW-PRE_CFG_W){1'b0}}, pre_count_reg};
            REG_WINDOW_LEN: prdata = {{(APB_DW-WIN_W){1'b0}}, window_len_reg};
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

    // item plan: pre-sample count limited by cap, record start and overlap
    always_comb
    begin
        hit       = val_reg > thr_reg;
        emit_plan = in_win_reg || hit;

        if ({{(INDEX_BITS-PRE_CFG_W){1'b0}}, pre_count_reg} > INDEX_BITS'(PRE_LIM))
            pre_cap = PRE_W'(PRE_LIM);
        else
            pre_cap = PRE_W'(pre_count_reg);

        if (cnt_reg < INDEX_BITS'(pre_cap))
            pre_cur = PRE_W'(cnt_reg);
        else
            pre_cur = pre_cap;

        gap = (cnt_reg > last_em_reg) ? (cnt_reg - last_em_reg - 1'b1) : '0;

        if (em_valid_reg && (INDEX_BITS'(pre_cur) > gap))
            pre_plan = PRE_W'(gap);
        else
            pre_plan = pre_cur;

        if (in_win_reg)
            wl_new = (win_left_reg != '0) ? (win_left_reg - 1'b1) : '0;
        else
            wl_new = (window_len_reg != '0) ? (window_len_reg - 1'b1) : '0;
    end

    // ring position
    always_comb
    begin
        pos_inc = {1'b0, pos_reg} + 1'b1;
        if (pos_inc >= (HIST_AW+1)'(HISTORY_DEPTH))
            pos_next = '0;
        else
            pos_next = pos_inc[HIST_AW-1:0];

        if (SUM_W'(pos_reg) >= SUM_W'(k_reg))
            slot_sum = SUM_W'(pos_reg) - SUM_W'(k_reg);
        else
            slot_sum = SUM_W'(pos_reg) + SUM_W'(HISTORY_DEPTH) - SUM_W'(k_reg);
    end

    // memory requests and output loads
    always_comb
    begin
        hist_req.rd_en   = (state_reg == S_RD);
        hist_req.rd_addr = slot_sum[HIST_AW-1:0];
        hist_req.wr_addr = pos_reg;
        hist_req.wr_data = val_reg;
        hist_req.wr_en   = ((state_reg == S_PLAN) && !emit_plan)
                         || ((state_reg == S_LAST) && out_free);

        out_load            = ((state_reg == S_PRE) || (state_reg == S_LAST)) && out_free;
        out_word_in.channel = chan_reg;
        if (state_reg == S_PRE)
        begin
            out_word_in.value = hist_rd_data;
            out_word_in.index = to_out_index(cur_reg - INDEX_BITS'(k_reg));
            out_word_in.last  = 1'b0;
        end
        else
        begin
            out_word_in.value = val_reg;
            out_word_in.index = to_out_index(cur_reg);
            out_word_in.last  = flag_reg;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            val_reg      <= '0;
            thr_reg      <= '0;
            chan_reg     <= '0;
            rlast_reg    <= 1'b0;
            in_win_reg   <= 1'b0;
            win_left_reg <= '0;
            cnt_reg      <= '0;
            cur_reg      <= '0;
            last_em_reg  <= '0;
            em_valid_reg <= 1'b0;
            pos_reg      <= '0;
            k_reg        <= '0;
            flag_reg     <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        val_reg   <= sample_value;
                        thr_reg   <= threshold;
                        chan_reg  <= channel_id;
                        rlast_reg <= record_last;
                        state_reg <= S_PLAN;
                    end
                end

                S_PLAN:
                begin
                    cur_reg  <= cnt_reg;
                    k_reg    <= in_win_reg ? '0 : pre_plan;
                    flag_reg <= (wl_new == '0) || rlast_reg;

                    if (emit_plan)
                    begin
                        last_em_reg <= cnt_reg;
                    end

                    // record end closes everything
                    if (rlast_reg)
                    begin
                        in_win_reg   <= 1'b0;
                        win_left_reg <= '0;
                        em_valid_reg <= 1'b0;
                        cnt_reg      <= '0;
                    end
                    else
                    begin
                        if (emit_plan)
                        begin
                            win_left_reg <= wl_new;
                            in_win_reg   <= (wl_new != '0);
                            em_valid_reg <= 1'b1;
                        end
                        if (cnt_reg < IDX_MAX)
                        begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end

                    if (!emit_plan)
                    begin
                        pos_reg   <= pos_next;
                        state_reg <= S_IDLE;
                    end
                    else if (!in_win_reg && (pre_plan != '0))
                    begin
                        state_reg <= S_RD;
                    end
                    else
                    begin
                        state_reg <= S_LAST;
                    end
                end

                S_RD:
                begin
                    state_reg <= S_PRE;
                end

                S_PRE:
                begin
                    if (out_free)
                    begin
                        k_reg     <= k_reg - 1'b1;
                        state_reg <= (k_reg == PRE_W'(1)) ? S_LAST : S_RD;
                    end
                end

                S_LAST:
                begin
                    if (out_free)
                    begin
                        pos_reg   <= pos_next;
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    trzs_hist_ram u_hist_ram (
        .clk     (clk),
        .req     (hist_req),
        .rd_data (hist_rd_data)
    );

    trzs_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .word_in   (out_word_in),
        .free      (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .word_out  (out_word)
    );

    assign out_value   = out_word.value;
    assign out_index   = out_word.index;
    assign out_channel = out_word.channel;
    assign roi_last    = out_word.last;

endmodule

@@ bench/roi_scoreboard_pkg.sv @@
`timescale 1ns / 1ps

package roi_scoreboard_pkg;

    import trzs_pkg::*;

    // One input word as offered to the block
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [VALUE_W-1:0] threshold;
        logic [CHAN_W-1:0]  channel;
        logic               rec_last;
    } adc_word_t;

    // Register indexes, byte address is 4 * index
    localparam int REG_PRE_COUNT  = 0;
    localparam int REG_WINDOW_LEN = 1;

    // Cap on printed mismatch lines
    localparam int MAX_REPORTS = 40;

    class roi_scoreboard;

        // Own copy of the block state
        logic [VALUE_W-1:0]   hist [HISTORY_DEPTH];
        int unsigned          hist_wr;
        bit                   in_roi;
        int unsigned          roi_left;
        longint unsigned      next_idx;
        longint unsigned      last_idx;
        longint unsigned      idx_max;
        bit                   any_emitted;
        logic [PRE_CFG_W-1:0] pre_count;
        logic [WIN_W-1:0]     window_len;

        // Words the block still owes, oldest first
        out_word_t            roi_words [$];

        int unsigned          errors;
        int unsigned          words_in;
        int unsigned          words_out;
        int unsigned          rois;

        function new();
            idx_max     = (64'd1 << INDEX_BITS) - 1;
            hist_wr     = 0;
            in_roi      = 1'b0;
            roi_left    = 0;
            next_idx    = 0;
            last_idx    = 0;
            any_emitted = 1'b0;
            pre_count   = PRE_COUNT_RESET;
            window_len  = WINDOW_LEN_RESET;
            errors      = 0;
            words_in    = 0;
            words_out   = 0;
            rois        = 0;
            foreach (hist[i])
                hist[i] = '0;
        endfunction

        function void write_register(int unsigned reg_idx, logic [APB_DW-1:0] data);
            if (reg_idx == REG_PRE_COUNT)
                pre_count = data[PRE_CFG_W-1:0];
            else if (reg_idx == REG_WINDOW_LEN)
                window_len = data[WIN_W-1:0];
        endfunction

        function int pending();
            return roi_words.size();
        endfunction

        function void queue_word(logic [VALUE_W-1:0] v, longint unsigned idx,
                                 logic [CHAN_W-1:0] ch, bit last);
            out_word_t w;
            w.value   = v;
            w.index   = idx[OUT_IDX_W-1:0];
            w.channel = ch;
            w.last    = last;
            roi_words.insert(roi_words.size(), w);
        endfunction

        // Accepted input word: work out the words it causes
        function void note_word(adc_word_t a);
            longint unsigned cur;
            longint unsigned pre;
            longint unsigned gap;
            out_word_t       w;
            int              n0;
            cur = next_idx;
            n0  = roi_words.size();
            words_in++;
            if (in_roi) begin
                // inside a region every word goes out, crossings included
                if (roi_left > 0)
                    roi_left--;
                queue_word(a.value, cur, a.channel, roi_left == 0);
                last_idx    = cur;
                any_emitted = 1'b1;
                if (roi_left == 0)
                    in_roi = 1'b0;
            end
            else if (a.value > a.threshold) begin
                // history words: capped, bounded by the record start and by
                // the last word already sent in this record
                pre = pre_count;
                if (pre > PRE_LIM)
                    pre = PRE_LIM;
                if (pre > cur)
                    pre = cur;
                if (any_emitted) begin
                    gap = (cur > last_idx) ? cur - last_idx - 1 : 0;
                    if (pre > gap)
                        pre = gap;
                end
                for (longint unsigned k = pre; k >= 1; k--)
                    queue_word(hist[(hist_wr + HISTORY_DEPTH - k) % HISTORY_DEPTH],
                               cur - k, a.channel, 1'b0);
                // a zero window behaves as one word
                roi_left = (window_len == 0) ? 0 : window_len - 1;
                queue_word(a.value, cur, a.channel, roi_left == 0);
                last_idx    = cur;
                any_emitted = 1'b1;
                in_roi      = (roi_left != 0);
                rois++;
            end

            hist[hist_wr] = a.value;
            hist_wr = (hist_wr + 1 >= HISTORY_DEPTH) ? 0 : hist_wr + 1;

            if (a.rec_last) begin
                // record end closes an open region on this word
                if (in_roi && roi_words.size() > n0) begin
                    w      = roi_words[roi_words.size()-1];
                    w.last = 1'b1;
                    roi_words[roi_words.size()-1] = w;
                end
                in_roi      = 1'b0;
                roi_left    = 0;
                any_emitted = 1'b0;
                next_idx    = 0;
            end
            else if (next_idx < idx_max) begin
                next_idx++;
            end
        endfunction

        function void report(string field, logic [31:0] exp_v, logic [31:0] got_v);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, field, exp_v, got_v);
        endfunction

        // Emitted word against the oldest expectation
        function void check_word(out_word_t got);
            out_word_t want;
            words_out++;
            if (roi_words.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t ns: word with none expected, actual value 0x%0h index %0d",
                             $time, got.value, got.index);
                return;
            end
            want = roi_words.pop_front();
            if (got.value !== want.value)
                report("out_value", want.value, got.value);
            if (got.index !== want.index)
                report("out_index", want.index, got.index);
            if (got.channel !== want.channel)
                report("out_channel", want.channel, got.channel);
            if (got.last !== want.last)
                report("roi_last", want.last, got.last);
        endfunction

    endclass

endpackage

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    import trzs_pkg::*;
    import roi_scoreboard_pkg::*;

    // Worst case: every word stalled and history bursts at full length
    localparam int unsigned LIMIT_CYCLES   = 1_500_000;
    // Longer than an item with a full history burst
    localparam int          SETTLE_CYCLES  = 50;
    // Input words per random phase
    localparam int unsigned PHASE_WORDS    = 65;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [VALUE_W-1:0]   sample_value;
    logic [VALUE_W-1:0]   threshold;
    logic [CHAN_W-1:0]    channel_id;
    logic                 record_last;
    logic                 out_valid;
    logic                 out_ready;
    logic [VALUE_W-1:0]   out_value;
    logic [OUT_IDX_W-1:0] out_index;
    logic [CHAN_W-1:0]    out_channel;
    logic                 roi_last;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    roi_scoreboard        sb;
    int unsigned          sender_idle_pct    = 0;
    int unsigned          receiver_stall_pct = 0;
    int unsigned          cycle_cnt          = 0;
    int unsigned          settings_used      = 0;

    threshold_roi_zero_suppress dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample_value (sample_value),
        .threshold    (threshold),
        .channel_id   (channel_id),
        .record_last  (record_last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_value    (out_value),
        .out_index    (out_index),
        .out_channel  (out_channel),
        .roi_last     (roi_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end

    initial
    begin : watchdog
        wait (cycle_cnt >= LIMIT_CYCLES);
        $display("FAILURE");
        $finish;
    end

    // Output side: random stalls
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Accepted words feed the predictor, emitted words are checked
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (out_valid === 1'b1 && out_ready)
                sb.check_word({out_value, out_index, out_channel, roi_last});
            if (in_valid && in_ready === 1'b1)
                sb.note_word({sample_value, threshold, channel_id, record_last});
        end
    end

    function automatic adc_word_t mk_word(int unsigned v, int unsigned thr,
                                          int unsigned ch, bit rl);
        adc_word_t a;
        a.value     = v[VALUE_W-1:0];
        a.threshold = thr[VALUE_W-1:0];
        a.channel   = ch[CHAN_W-1:0];
        a.rec_last  = rl;
        return a;
    endfunction

    // Offer one word, with random idle cycles first; returns at the falling
    // edge after acceptance
    task automatic send_word(input adc_word_t a);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        sample_value <= a.value;
        threshold    <= a.threshold;
        channel_id   <= a.channel;
        record_last  <= a.rec_last;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        @(negedge clk);
    endtask

    // Hold the sender until every expected word has come out
    task automatic drain_outputs();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending() != 0);
    endtask

    // One register write followed by a read back
    task automatic apb_access(input int unsigned reg_idx, input logic [APB_DW-1:0] data);
        logic [APB_DW-1:0] rd;
        logic [APB_DW-1:0] mask;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(reg_idx * 4);
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        @(negedge clk);
        sb.write_register(reg_idx, data);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        rd = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        mask = (reg_idx == REG_PRE_COUNT) ? (APB_DW'(1) << PRE_CFG_W) - 1
                                          : (APB_DW'(1) << WIN_W) - 1;
        if (rd !== (data & mask))
            sb.report("prdata", data & mask, rd);
    endtask

    // New settings only once the block has gone quiet
    task automatic set_config(input int unsigned pre, input int unsigned win);
        drain_outputs();
        repeat (SETTLE_CYCLES) @(negedge clk);
        apb_access(REG_PRE_COUNT, pre);
        apb_access(REG_WINDOW_LEN, win);
        settings_used++;
    endtask

    // One record: mostly well formed with pulses over a fixed threshold,
    // sometimes unrelated noise words
    task automatic random_record(output int unsigned sent);
        adc_word_t   a;
        int unsigned len;
        int unsigned pulse_pct;
        int unsigned thr;
        sent = 0;
        if ($urandom_range(99) < 15)
        begin
            len = $urandom_range(1, 6);
            for (int unsigned i = 0; i < len; i++)
            begin
                a = mk_word($urandom, $urandom, $urandom, $urandom_range(3) == 0);
                send_word(a);
                sent++;
            end
        end
        else
        begin
            thr       = $urandom_range(65534);
            len       = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 48);
            pulse_pct = $urandom_range(3, 30);
            a         = mk_word(0, thr, $urandom, 1'b0);
            for (int unsigned i = 0; i < len; i++)
            begin
                if ($urandom_range(99) < pulse_pct)
                    a.value = $urandom_range(65535, thr + 1);
                else
                    a.value = $urandom_range(thr, 0);
                a.rec_last = (i == len - 1);
                send_word(a);
                sent++;
            end
        end
    endtask

    task automatic random_phase(input int unsigned pre, input int unsigned win,
                                input int unsigned idle, input int unsigned stall,
                                input int unsigned n_words);
        int unsigned sent;
        int unsigned got;
        bit          paused;
        set_config(pre, win);
        sender_idle_pct    = idle;
        receiver_stall_pct = stall;
        sent   = 0;
        paused = 1'b0;
        while (sent < n_words)
        begin
            random_record(got);
            sent += got;
            if (!paused && sent >= n_words / 2)
            begin
                drain_outputs();
                paused = 1'b1;
            end
        end
    endtask

    initial
    begin
        sb           = new();
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        sample_value = '0;
        threshold    = '0;
        channel_id   = '0;
        record_last  = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: field extremes, early crossing, crossing inside a region,
        // partial overlap, record end closing a region
        set_config(3, 3);
        send_word(mk_word(0, 0, 0, 1'b0));
        send_word(mk_word(0, 0, 0, 1'b0));
        send_word(mk_word(65535, 0, 0, 1'b0));
        send_word(mk_word(1, 0, 0, 1'b0));
        send_word(mk_word(65535, 0, 0, 1'b0));
        send_word(mk_word(0, 0, 0, 1'b0));
        send_word(mk_word(9, 0, 0, 1'b0));
        send_word(mk_word(1, 0, 0, 1'b1));
        // equal to threshold never opens a region
        send_word(mk_word(65535, 65535, 1023, 1'b0));
        send_word(mk_word(0, 65535, 1023, 1'b1));
        // single word record that crosses
        send_word(mk_word(101, 100, 'h2AA, 1'b1));
        // region closing on its own before the record end
        send_word(mk_word('h8000, 'h7FFF, 'h155, 1'b0));
        send_word(mk_word('h7FFF, 'h7FFF, 'h155, 1'b0));
        send_word(mk_word('hFFFF, 'h7FFF, 'h155, 1'b0));
        send_word(mk_word(0, 'h7FFF, 'h155, 1'b1));
        // zero window: each region ends on its crossing word
        set_config(2, 0);
        send_word(mk_word('h00FF, 'h00FF, 'h3FF, 1'b0));
        send_word(mk_word('h0000, 'h00FF, 'h3FF, 1'b0));
        send_word(mk_word('h0100, 'h00FF, 'h3FF, 1'b0));
        send_word(mk_word('hFFFF, 'h00FF, 'h3FF, 1'b0));
        send_word(mk_word('h00FF, 'h00FF, 'h3FF, 1'b0));
        send_word(mk_word('h1234, 'h00FF, 'h3FF, 1'b1));

        // Random phases over several settings and idle patterns
        random_phase(0, 1, 0, 0, PHASE_WORDS);
        random_phase(31, 3, 80, 0, PHASE_WORDS);
        random_phase(16, 255, 0, 80, PHASE_WORDS);
        random_phase(5, 0, 21, 21, PHASE_WORDS);
        random_phase(10, 40, 0, 0, PHASE_WORDS);
        random_phase(16, 6, 21, 21, PHASE_WORDS);

        drain_outputs();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Checked %0d output words from %0d input words over %0d register settings.",
                 sb.words_out, sb.words_in, settings_used);
        $display("%0d regions opened, with overlap, zero window and record end cases.",
                 sb.rois);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
